// File: rtl/dlbm_pkg.sv
// Shared types, constants and register indexes of the dual LFSR byte masker.
package dlbm_pkg;

	localparam int unsigned SHORT_LENGTH = 17;
	localparam int unsigned LONG_LENGTH = 111;
	localparam int unsigned SHORT_TAP = 14;
	localparam int unsigned LONG_TAP = 101;
	localparam int unsigned LONG_LOW_BITS = 64;
	localparam int unsigned LONG_HIGH_BITS = LONG_LENGTH - LONG_LOW_BITS;
	localparam int unsigned POS_BITS = 16;
	localparam int unsigned BYTE_BITS = 8;
	localparam int unsigned CFG_DATA_BITS = 64;
	localparam int unsigned CFG_INDEX_BITS = 3;

	localparam logic [SHORT_LENGTH-1:0] SEED_SHORT_RST = SHORT_LENGTH'(1);
	localparam logic [LONG_LOW_BITS-1:0] SEED_LONG_LOW_RST = LONG_LOW_BITS'(1);
	localparam logic [LONG_HIGH_BITS-1:0] SEED_LONG_HIGH_RST = '0;
	localparam logic MASK_WHOLE_RST = 1'b1;
	localparam logic [POS_BITS-1:0] HEADER_BYTES_RST = POS_BITS'(100);

	typedef enum logic [CFG_INDEX_BITS-1:0] {
		CFG_SEED_SHORT     = 3'd0,
		CFG_SEED_LONG_LOW  = 3'd1,
		CFG_SEED_LONG_HIGH = 3'd2,
		CFG_MASK_WHOLE     = 3'd3,
		CFG_HEADER_BYTES   = 3'd4
	} cfg_idx_t;

	typedef struct packed {
		logic [SHORT_LENGTH-1:0] seed_short;
		logic [LONG_LENGTH-1:0]  seed_long;
		logic                    mask_whole_file;
		logic [POS_BITS-1:0]     header_bytes;
	} cfg_t;

	typedef struct packed {
		logic fire;
		logic start_of_file;
	} step_t;

	typedef struct packed {
		logic key_bit;
		logic was_masked;
	} key_t;

endpackage

// File: rtl/dlbm_cfg_regs.sv
// Configuration register file of the dual LFSR byte masker.
module dlbm_cfg_regs (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 cfg_we,
	input  logic [dlbm_pkg::CFG_INDEX_BITS-1:0]  cfg_index,
	input  logic [dlbm_pkg::CFG_DATA_BITS-1:0]   cfg_wdata,
	output dlbm_pkg::cfg_t                       cfg
);

	logic [dlbm_pkg::SHORT_LENGTH-1:0]   seed_short_q;
	logic [dlbm_pkg::LONG_LOW_BITS-1:0]  seed_long_low_q;
	logic [dlbm_pkg::LONG_HIGH_BITS-1:0] seed_long_high_q;
	logic                                mask_whole_q;
	logic [dlbm_pkg::POS_BITS-1:0]       header_bytes_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			seed_short_q     <= dlbm_pkg::SEED_SHORT_RST;
			seed_long_low_q  <= dlbm_pkg::SEED_LONG_LOW_RST;
			seed_long_high_q <= dlbm_pkg::SEED_LONG_HIGH_RST;
			mask_whole_q     <= dlbm_pkg::MASK_WHOLE_RST;
			header_bytes_q   <= dlbm_pkg::HEADER_BYTES_RST;
		end else if (cfg_we) begin
			unique case (dlbm_pkg::cfg_idx_t'(cfg_index))
				dlbm_pkg::CFG_SEED_SHORT: begin
					seed_short_q <= cfg_wdata[dlbm_pkg::SHORT_LENGTH-1:0];
				end
				dlbm_pkg::CFG_SEED_LONG_LOW: begin
					seed_long_low_q <= cfg_wdata;
				end
				dlbm_pkg::CFG_SEED_LONG_HIGH: begin
					seed_long_high_q <= cfg_wdata[dlbm_pkg::LONG_HIGH_BITS-1:0];
				end
				dlbm_pkg::CFG_MASK_WHOLE: begin
					mask_whole_q <= cfg_wdata[0];
				end
				dlbm_pkg::CFG_HEADER_BYTES: begin
					header_bytes_q <= cfg_wdata[dlbm_pkg::POS_BITS-1:0];
				end
				default: begin
				end
			endcase
		end
	end

	assign cfg.seed_short      = seed_short_q;
	assign cfg.seed_long       = {seed_long_high_q, seed_long_low_q};
	assign cfg.mask_whole_file = mask_whole_q;
	assign cfg.header_bytes    = header_bytes_q;

endmodule

// File: rtl/dlbm_keystream.sv
// Two Fibonacci LFSRs, their combined key bit and the header byte counter.
module dlbm_keystream (
	input  logic           clk,
	input  logic           arst_n,
	input  dlbm_pkg::cfg_t cfg,
	input  dlbm_pkg::step_t step,
	output dlbm_pkg::key_t key
);

	logic [dlbm_pkg::SHORT_LENGTH-1:0] short_q;
	logic [dlbm_pkg::LONG_LENGTH-1:0]  long_q;
	logic [dlbm_pkg::POS_BITS-1:0]     pos_q;

	logic [dlbm_pkg::SHORT_LENGTH-1:0] short_cur;
	logic [dlbm_pkg::LONG_LENGTH-1:0]  long_cur;
	logic [dlbm_pkg::POS_BITS-1:0]     pos_cur;
	logic                              is_header;
	logic                              s_new;
	logic                              t_new;

	// A start of file reloads all three registers before a byte is handled.
	always_comb begin
		short_cur = step.start_of_file ? cfg.seed_short : short_q;
		long_cur  = step.start_of_file ? cfg.seed_long : long_q;
		pos_cur   = step.start_of_file ? '0 : pos_q;
		is_header = !cfg.mask_whole_file && (pos_cur < cfg.header_bytes);
		s_new     = short_cur[dlbm_pkg::SHORT_TAP-1] ^ short_cur[dlbm_pkg::SHORT_LENGTH-1];
		t_new     = long_cur[dlbm_pkg::LONG_TAP-1] ^ long_cur[dlbm_pkg::LONG_LENGTH-1];
		key.was_masked = !is_header;
		key.key_bit    = !is_header && (s_new ^ t_new);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			short_q <= dlbm_pkg::SEED_SHORT_RST;
			long_q  <= {dlbm_pkg::SEED_LONG_HIGH_RST, dlbm_pkg::SEED_LONG_LOW_RST};
			pos_q   <= '0;
		end else if (step.fire) begin
			if (is_header) begin
				short_q <= short_cur;
				long_q  <= long_cur;
				pos_q   <= pos_cur + dlbm_pkg::POS_BITS'(1);
			end else begin
				short_q <= {short_cur[dlbm_pkg::SHORT_LENGTH-2:0], s_new};
				long_q  <= {long_cur[dlbm_pkg::LONG_LENGTH-2:0], t_new};
				pos_q   <= pos_cur;
			end
		end
	end

endmodule

// File: rtl/dual_lfsr_byte_masker.sv
// Top level of the dual LFSR byte masker: input stage, keystream and result register.
// A request accepted into the input stage is masked and moves into the result register
// once the result register is free, and is then offered on the output.
// Throughput: one request per cycle while the output is not stalled, set by the LFSR step.
// Reset: control clears at once, configuration returns to its reset values and
// both LFSRs hold the reset seeds with the header count at zero.
module dual_lfsr_byte_masker (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	input  logic [7:0]                          s_tdata,  // data_byte[7:0]
	input  logic                                s_tuser,  // start_of_file
	output logic                                m_tvalid,
	input  logic                                m_tready,
	output logic [7:0]                          m_tdata,  // masked_byte[7:0]
	output logic [1:0]                          m_tuser,  // was_masked, key_bit
	input  logic                                cfg_we,
	input  logic [dlbm_pkg::CFG_INDEX_BITS-1:0] cfg_index,
	input  logic [dlbm_pkg::CFG_DATA_BITS-1:0]  cfg_wdata
);

	dlbm_pkg::cfg_t  cfg;
	dlbm_pkg::step_t step;
	dlbm_pkg::key_t  key;

	logic                           valid_s1;
	logic [dlbm_pkg::BYTE_BITS-1:0] data_s1;
	logic                           sof_s1;
	logic                           valid_s2;
	logic [dlbm_pkg::BYTE_BITS-1:0] data_s2;
	logic                           key_s2;
	logic                           masked_s2;
	logic                           ready_s2;

	dlbm_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	assign ready_s2           = !valid_s2 || m_tready;
	assign s_tready           = !valid_s1 || ready_s2;
	assign step.fire          = valid_s1 && ready_s2;
	assign step.start_of_file = sof_s1;

	dlbm_keystream u_keystream (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.step   (step),
		.key    (key)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
		end else begin
			if (s_tready) begin
				valid_s1 <= s_tvalid;
			end
			if (ready_s2) begin
				valid_s2 <= valid_s1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (s_tvalid && s_tready) begin
			data_s1 <= s_tdata;
			sof_s1  <= s_tuser;
		end
		if (step.fire) begin
			data_s2   <= {data_s1[dlbm_pkg::BYTE_BITS-1:1], data_s1[0] ^ key.key_bit};
			key_s2    <= key.key_bit;
			masked_s2 <= key.was_masked;
		end
	end

	assign m_tvalid = valid_s2;
	assign m_tdata  = data_s2;
	assign m_tuser  = {masked_s2, key_s2};

`ifndef SYNTHESIS
	a_header_no_key: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && !masked_s2 |-> !key_s2)
		else $error("Header byte carries a key bit.");

	a_whole_file_masked: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire && cfg.mask_whole_file |-> key.was_masked)
		else $error("Byte passed unmasked with whole-file masking on.");

	a_stall_keeps_s1: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s1 && !ready_s2 |=> valid_s1 && $stable(data_s1) && $stable(sof_s1))
		else $error("Input stage lost a request during a stall.");

	a_fire_fills_s2: assert property (@(posedge clk) disable iff (!arst_n)
		step.fire |=> valid_s2)
		else $error("Processed request did not reach the result register.");
`endif

endmodule
